// File: src/windowed_rms_current_meter_core_macros.svh
// Assertion macros for the windowed RMS current meter checker.
// No dependencies; taken in by the checker file.
`ifndef WINDOWED_RMS_CURRENT_METER_CORE_MACROS_SVH
`define WINDOWED_RMS_CURRENT_METER_CORE_MACROS_SVH

// same-cycle implication
`define WRMS_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("wrms assertion failed");

// next-cycle implication
`define WRMS_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("wrms assertion failed");

`endif

// File: src/wrms_pkg.sv
// Shared types and constants of the windowed RMS current meter.
// No dependencies; used by every RTL file of the block.
package wrms_pkg;

	localparam int SAMPLE_W = 12;
	localparam int CFG_W = 24;
	localparam int GAIN_W = 24;
	localparam int OFFSET_W = 16;
	localparam int DZ_W = 17;
	localparam int AC_W = 17;
	localparam int DC_W = 19;
	localparam int NSAMP_W = 17;
	localparam int DEFAULT_MAX_WINDOW = 65536;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd4000979;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd0;
	localparam logic [DZ_W-1:0] DZ_RESET = 17'd300;

	localparam logic [19:0] AC_MAX = 20'd131071;
	localparam logic [19:0] DC_POS_MAX = 20'd262143;
	localparam logic [19:0] DC_NEG_MAX = 20'd262144;

	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_DEADZONE = 2'd2;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
	} alu_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_NSQ,
		ST_SS,
		ST_SQRT,
		ST_RG,
		ST_DIVA,
		ST_DCS,
		ST_NOFF,
		ST_MG,
		ST_DIVD,
		ST_DONE
	} seq_state_t;

endpackage

// File: src/wrms_acc.sv
// Window accumulators: per-phase sum and sum of squares, bus sum, sample count.
// Depends on wrms_pkg.
module wrms_acc #(
	parameter int MAX_WINDOW = wrms_pkg::DEFAULT_MAX_WINDOW,
	parameter int CNT_W = 17,
	parameter int SUM_W = 29,
	parameter int SQ_W = 41
) (
	input  logic clk,
	input  logic arst_n,
	input  logic add,
	input  logic clear,
	input  logic [wrms_pkg::SAMPLE_W-1:0] smp_a,
	input  logic [wrms_pkg::SAMPLE_W-1:0] smp_b,
	input  logic [wrms_pkg::SAMPLE_W-1:0] smp_c,
	input  logic [wrms_pkg::SAMPLE_W-1:0] smp_bus,
	output logic [2:0][SUM_W-1:0] sum,
	output logic [2:0][SQ_W-1:0] sq,
	output logic [SUM_W-1:0] bus_sum,
	output logic [CNT_W-1:0] count,
	output logic full
);

	logic [2:0][SUM_W-1:0] sum_q;
	logic [2:0][SQ_W-1:0] sq_q;
	logic [SUM_W-1:0] bus_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0][wrms_pkg::SAMPLE_W-1:0] x;
	logic [2:0][2*wrms_pkg::SAMPLE_W-1:0] xsq;

	assign x = {smp_c, smp_b, smp_a};
	// this request brings the count to the window limit
	assign full = (cnt_q == CNT_W'(MAX_WINDOW - 1));

	always_comb begin
		for (int i = 0; i < 3; i++)
			xsq[i] = x[i] * x[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q <= '0;
			bus_q <= '0;
			cnt_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
			sq_q <= '0;
			bus_q <= '0;
			cnt_q <= '0;
		end else if (add) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_q[i] + SUM_W'(x[i]);
				sq_q[i] <= sq_q[i] + SQ_W'(xsq[i]);
			end
			bus_q <= bus_q + SUM_W'(smp_bus);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sum = sum_q;
	assign sq = sq_q;
	assign bus_sum = bus_q;
	assign count = cnt_q;

endmodule

// File: src/wrms_alu.sv
// Bit-serial arithmetic unit: shift-add multiply, restoring divide, digit square root.
// One bit (or one root digit) per cycle. Depends on wrms_pkg.
module wrms_alu #(
	parameter int W = 74,
	parameter int NW = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  wrms_pkg::alu_cmd_t cmd,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic done,
	output logic [W-1:0] res
);

	localparam int CW = $clog2(W + 1);

	logic busy_q, done_q;
	wrms_pkg::alu_op_t op_q;
	logic [W-1:0] x_q, y_q, z_q;
	logic [NW-1:0] rem_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0] x_n, y_n, z_n, t;
	logic [NW:0] shl;
	logic [NW-1:0] rem_n;
	logic ge, fin;

	always_comb begin
		x_n = x_q;
		y_n = y_q;
		z_n = z_q;
		rem_n = rem_q;
		t = z_q + x_q;
		shl = {rem_q, z_q[W-1]};
		ge = 1'b0;
		fin = 1'b0;
		unique case (op_q)
			wrms_pkg::ALU_MUL: begin
				z_n = y_q[0] ? z_q + x_q : z_q;
				x_n = x_q << 1;
				y_n = y_q >> 1;
				fin = (y_n == '0);
			end
			wrms_pkg::ALU_DIV: begin
				ge = (shl >= {1'b0, x_q[NW-1:0]});
				rem_n = ge ? NW'(shl - {1'b0, x_q[NW-1:0]}) : NW'(shl);
				z_n = {z_q[W-2:0], ge};
				fin = (cnt_q == CW'(1));
			end
			wrms_pkg::ALU_SQRT: begin
				ge = (y_q >= t);
				y_n = ge ? y_q - t : y_q;
				z_n = ge ? (z_q >> 1) + x_q : z_q >> 1;
				x_n = x_q >> 2;
				fin = (x_n == '0);
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= wrms_pkg::ALU_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (fin) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			unique case (cmd.op)
				wrms_pkg::ALU_MUL: begin
					x_q <= a;
					y_q <= b;
					z_q <= '0;
				end
				wrms_pkg::ALU_DIV: begin
					x_q <= b;
					y_q <= '0;
					z_q <= a;
				end
				default: begin
					x_q <= W'(1) << (W - 2);
					y_q <= a;
					z_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign res = z_q;

endmodule

// File: src/windowed_rms_current_meter_core.sv
// Top level of the windowed RMS current meter: config registers, sequencer, result register.
// Depends on wrms_pkg, wrms_acc, wrms_alu.
//
//  channel | direction | handshake          | payload
//  in      | to core   | in_valid/in_stall  | phase_a/b/c_sample, bus_sample, window_end
//  out     | from core | out_valid/out_stall| phase_a/b/c_rms_ma, bus_mean_ma, window_samples
//  cfg     | to core   | cfg_we             | cfg_index, cfg_wdata
//
// A request that does not close the window is added to the accumulators without stalling the input.
// A closing request runs the serial unit: per phase two multiplies, a root and a
// multiply/divide, then for the bus two multiplies and a divide.
// in_stall is high from the closing request until the result moves to the output
// register; a pending output holds that move, and with it the next window's input.
module windowed_rms_current_meter_core #(
	parameter int MAX_WINDOW = wrms_pkg::DEFAULT_MAX_WINDOW
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [wrms_pkg::SAMPLE_W-1:0] phase_a_sample,
	input  logic [wrms_pkg::SAMPLE_W-1:0] phase_b_sample,
	input  logic [wrms_pkg::SAMPLE_W-1:0] phase_c_sample,
	input  logic [wrms_pkg::SAMPLE_W-1:0] bus_sample,
	input  logic window_end,
	output logic out_valid,
	input  logic out_stall,
	output logic [wrms_pkg::AC_W-1:0] phase_a_rms_ma,
	output logic [wrms_pkg::AC_W-1:0] phase_b_rms_ma,
	output logic [wrms_pkg::AC_W-1:0] phase_c_rms_ma,
	output logic signed [wrms_pkg::DC_W-1:0] bus_mean_ma,
	output logic [wrms_pkg::NSAMP_W-1:0] window_samples,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [wrms_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = wrms_pkg::SAMPLE_W + CNT_W;
	localparam int SQ_W = 2 * wrms_pkg::SAMPLE_W + CNT_W;
	localparam int W = 2 * CNT_W + 40;

	wrms_pkg::seq_state_t state_q, state_n;
	wrms_pkg::alu_cmd_t cmd;

	logic [wrms_pkg::GAIN_W-1:0] gain_q;
	logic [wrms_pkg::OFFSET_W-1:0] offset_q;
	logic [wrms_pkg::DZ_W-1:0] dz_q;

	logic [2:0][SUM_W-1:0] sum;
	logic [2:0][SQ_W-1:0] sq;
	logic [SUM_W-1:0] bus_sum;
	logic [CNT_W-1:0] n;
	logic full, in_acc, acc_clear, load_out;

	logic [W-1:0] alu_a, alu_b, res, t1_q, pos, mag;
	logic alu_done, negative, neg_q;
	logic [1:0] ch_q;
	logic [2:0][wrms_pkg::AC_W-1:0] ac_q;
	logic [wrms_pkg::DC_W-1:0] dc_q, dc_val, dc_mag;
	logic [wrms_pkg::AC_W-1:0] ac_val;
	logic out_valid_q;
	logic [wrms_pkg::AC_W-1:0] out_a_q, out_b_q, out_c_q;
	logic [wrms_pkg::DC_W-1:0] out_dc_q;
	logic [wrms_pkg::NSAMP_W-1:0] out_n_q;

	assign in_stall = (state_q != wrms_pkg::ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= wrms_pkg::GAIN_RESET;
			offset_q <= wrms_pkg::OFFSET_RESET;
			dz_q <= wrms_pkg::DZ_RESET;
		end else if (cfg_we) begin
			priority case (cfg_index)
				wrms_pkg::REG_GAIN: gain_q <= cfg_wdata[wrms_pkg::GAIN_W-1:0];
				wrms_pkg::REG_OFFSET: offset_q <= cfg_wdata[wrms_pkg::OFFSET_W-1:0];
				wrms_pkg::REG_DEADZONE: dz_q <= cfg_wdata[wrms_pkg::DZ_W-1:0];
				default: ;
			endcase
		end
	end

	wrms_acc #(
		.MAX_WINDOW(MAX_WINDOW),
		.CNT_W(CNT_W),
		.SUM_W(SUM_W),
		.SQ_W(SQ_W)
	) u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.add(in_acc),
		.clear(acc_clear),
		.smp_a(phase_a_sample),
		.smp_b(phase_b_sample),
		.smp_c(phase_c_sample),
		.smp_bus(bus_sample),
		.sum(sum),
		.sq(sq),
		.bus_sum(bus_sum),
		.count(n),
		.full(full)
	);

	wrms_alu #(
		.W(W),
		.NW(CNT_W)
	) u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.a(alu_a),
		.b(alu_b),
		.done(alu_done),
		.res(res)
	);

	// bus magnitude: 16*sum against N*offset (res holds N*offset in ST_NOFF)
	assign pos = W'(bus_sum) << 4;
	assign negative = res > pos;
	assign mag = negative ? res - pos : pos - res;

	always_comb begin
		if (res < W'(dz_q))
			ac_val = '0;
		else if (res > W'(wrms_pkg::AC_MAX))
			ac_val = wrms_pkg::AC_W'(wrms_pkg::AC_MAX);
		else
			ac_val = res[wrms_pkg::AC_W-1:0];

		if (neg_q)
			dc_mag = (res > W'(wrms_pkg::DC_NEG_MAX)) ?
				wrms_pkg::DC_W'(wrms_pkg::DC_NEG_MAX) : res[wrms_pkg::DC_W-1:0];
		else
			dc_mag = (res > W'(wrms_pkg::DC_POS_MAX)) ?
				wrms_pkg::DC_W'(wrms_pkg::DC_POS_MAX) : res[wrms_pkg::DC_W-1:0];

		if (res < W'(dz_q))
			dc_val = '0;
		else if (neg_q)
			dc_val = -dc_mag;
		else
			dc_val = dc_mag;
	end

	always_comb begin
		state_n = state_q;
		cmd.start = 1'b0;
		cmd.op = wrms_pkg::ALU_MUL;
		alu_a = '0;
		alu_b = '0;
		acc_clear = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			wrms_pkg::ST_IDLE: begin
				if (in_acc && (window_end || full))
					state_n = wrms_pkg::ST_START;
			end
			wrms_pkg::ST_START: begin
				cmd.start = 1'b1;
				alu_a = W'(sq[ch_q]);
				alu_b = W'(n);
				state_n = wrms_pkg::ST_NSQ;
			end
			wrms_pkg::ST_NSQ: begin
				if (alu_done) begin
					cmd.start = 1'b1;
					alu_a = W'(sum[ch_q]);
					alu_b = W'(sum[ch_q]);
					state_n = wrms_pkg::ST_SS;
				end
			end
			wrms_pkg::ST_SS: begin
				if (alu_done) begin
					cmd.start = 1'b1;
					cmd.op = wrms_pkg::ALU_SQRT;
					alu_a = t1_q - res;
					state_n = wrms_pkg::ST_SQRT;
				end
			end
			wrms_pkg::ST_SQRT: begin
				if (alu_done) begin
					cmd.start = 1'b1;
					alu_a = res;
					alu_b = W'(gain_q);
					state_n = wrms_pkg::ST_RG;
				end
			end
			wrms_pkg::ST_RG: begin
				if (alu_done) begin
					cmd.start = 1'b1;
					cmd.op = wrms_pkg::ALU_DIV;
					alu_a = res >> 16;
					alu_b = W'(n);
					state_n = wrms_pkg::ST_DIVA;
				end
			end
			wrms_pkg::ST_DIVA: begin
				if (alu_done)
					state_n = (ch_q == 2'd2) ? wrms_pkg::ST_DCS : wrms_pkg::ST_START;
			end
			wrms_pkg::ST_DCS: begin
				cmd.start = 1'b1;
				alu_a = W'(n);
				alu_b = W'(offset_q);
				state_n = wrms_pkg::ST_NOFF;
			end
			wrms_pkg::ST_NOFF: begin
				if (alu_done) begin
					cmd.start = 1'b1;
					alu_a = mag;
					alu_b = W'(gain_q);
					state_n = wrms_pkg::ST_MG;
				end
			end
			wrms_pkg::ST_MG: begin
				if (alu_done) begin
					cmd.start = 1'b1;
					cmd.op = wrms_pkg::ALU_DIV;
					alu_a = res >> 20;
					alu_b = W'(n);
					state_n = wrms_pkg::ST_DIVD;
				end
			end
			wrms_pkg::ST_DIVD: begin
				if (alu_done)
					state_n = wrms_pkg::ST_DONE;
			end
			wrms_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					acc_clear = 1'b1;
					state_n = wrms_pkg::ST_IDLE;
				end
			end
			default: state_n = wrms_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrms_pkg::ST_IDLE;
			ch_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == wrms_pkg::ST_IDLE)
				ch_q <= '0;
			else if (state_q == wrms_pkg::ST_DIVA && alu_done)
				ch_q <= ch_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wrms_pkg::ST_NSQ && alu_done)
			t1_q <= res;
		if (state_q == wrms_pkg::ST_DIVA && alu_done)
			ac_q[ch_q] <= ac_val;
		if (state_q == wrms_pkg::ST_NOFF && alu_done)
			neg_q <= negative;
		if (state_q == wrms_pkg::ST_DIVD && alu_done)
			dc_q <= dc_val;
		if (load_out) begin
			out_a_q <= ac_q[0];
			out_b_q <= ac_q[1];
			out_c_q <= ac_q[2];
			out_dc_q <= dc_q;
			out_n_q <= wrms_pkg::NSAMP_W'(n);
		end
	end

	assign out_valid = out_valid_q;
	assign phase_a_rms_ma = out_a_q;
	assign phase_b_rms_ma = out_b_q;
	assign phase_c_rms_ma = out_c_q;
	assign bus_mean_ma = out_dc_q;
	assign window_samples = out_n_q;

endmodule

// File: src/wrms_checker.sv
// Port-level checker for the windowed RMS current meter, bound to the top level.
// Depends on wrms_pkg and windowed_rms_current_meter_core_macros.svh.
`include "windowed_rms_current_meter_core_macros.svh"

module wrms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic window_end,
	input logic out_valid,
	input logic out_stall,
	input logic [wrms_pkg::AC_W-1:0] phase_a_rms_ma,
	input logic [wrms_pkg::NSAMP_W-1:0] window_samples
);

	// a stalled result holds
	`WRMS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(phase_a_rms_ma) && $stable(window_samples))
	// a closing request blocks the input while the result is computed
	`WRMS_ASSERT_NXT(a_close_stalls, clk, arst_n, in_valid && !in_stall && window_end, in_stall)
	// a result only appears after a compute phase
	`WRMS_ASSERT_IMP(a_load_after_busy, clk, arst_n, $rose(out_valid), $past(in_stall))
	// no back-to-back results without a compute phase between them
	`WRMS_ASSERT_NXT(a_no_double, clk, arst_n, out_valid && !out_stall, !out_valid || $past(in_stall))

endmodule

bind windowed_rms_current_meter_core wrms_checker u_wrms_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.window_end(window_end),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.phase_a_rms_ma(phase_a_rms_ma),
	.window_samples(window_samples)
);
